// ===== sv/rmq_pkg.sv =====
// Shared types, widths and helpers for the rotation matrix to quaternion block.
// No dependencies.
package rmq_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = DATA_WIDTH - 2;
  localparam int EXT_W      = DATA_WIDTH + 3;
  localparam int NUM_W      = DATA_WIDTH + 1;
  localparam int T_W        = DATA_WIDTH + 1;
  localparam int V_W        = 2 * DATA_WIDTH;
  localparam int ROOT_W     = DATA_WIDTH;
  localparam int DEN_W      = DATA_WIDTH + 1;
  localparam int Q_W        = DATA_WIDTH + 1;
  localparam int WIDE_W     = V_W + 2;
  localparam int SQ_STAGES  = ROOT_W;
  localparam int DV_STAGES  = Q_W + 2;

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic signed [NUM_W-1:0]      num_t;

  typedef enum logic [1:0] {
    SEL_W,
    SEL_X,
    SEL_Y,
    SEL_Z
  } sel_t;

  typedef struct packed {
    sel_t              sel;
    num_t              n0;
    num_t              n1;
    num_t              n2;
    logic [V_W-1:0]    rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic           neg;
    logic           ovf;
    logic [V_W-1:0] rem;
    logic [Q_W-1:0] q;
  } lane_t;

  typedef struct packed {
    sel_t              sel;
    logic [ROOT_W-2:0] big;
    logic [DEN_W-1:0]  den;
    lane_t             l0;
    lane_t             l1;
    lane_t             l2;
  } dv_t;

  function automatic lane_t lane_init(input num_t n, input logic [ROOT_W-1:0] root);
    lane_t           l;
    logic [NUM_W-1:0] mag;
    mag   = n[NUM_W-1] ? (NUM_W'(0) - NUM_W'(n)) : NUM_W'(n);
    l.neg = n[NUM_W-1];
    l.ovf = 1'b0;
    l.q   = '0;
    l.rem = (V_W'(mag) << FRAC_BITS) + V_W'(root);
    return l;
  endfunction

endpackage

// ===== sv/rmq_mat_if.sv =====
// Matrix input channel: valid/ready handshake with nine Q2.30 elements.
// Depends on rmq_pkg.
interface rmq_mat_if;
  logic           valid;
  logic           ready;
  rmq_pkg::word_t rot_00;
  rmq_pkg::word_t rot_01;
  rmq_pkg::word_t rot_02;
  rmq_pkg::word_t rot_10;
  rmq_pkg::word_t rot_11;
  rmq_pkg::word_t rot_12;
  rmq_pkg::word_t rot_20;
  rmq_pkg::word_t rot_21;
  rmq_pkg::word_t rot_22;

  modport source (output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                  rot_20, rot_21, rot_22, input ready);
  modport sink (input valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                rot_20, rot_21, rot_22, output ready);
endinterface

// ===== sv/rmq_quat_if.sv =====
// Quaternion output channel: valid/ready handshake with four Q2.30 components.
// Depends on rmq_pkg.
interface rmq_quat_if;
  logic           valid;
  logic           ready;
  rmq_pkg::word_t quat_w;
  rmq_pkg::word_t quat_x;
  rmq_pkg::word_t quat_y;
  rmq_pkg::word_t quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ===== sv/rmq_front.sv =====
// Front stage: trace, branch select, clamped square-root argument, numerators.
// Depends on rmq_pkg and rmq_mat_if.
module rmq_front (
  input  logic          clk,
  input  logic          rst,
  rmq_mat_if.sink       mat,
  output logic          out_valid,
  input  logic          out_ready,
  output rmq_pkg::sq_t  out_data
);

  logic signed [rmq_pkg::EXT_W-1:0] e00, e11, e22, one, trace, t;
  logic [rmq_pkg::T_W-1:0]          t_c;
  rmq_pkg::num_t                    d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;
  rmq_pkg::sq_t                     nxt;
  logic                             vld;

  always_comb begin
    e00    = rmq_pkg::EXT_W'(mat.rot_00);
    e11    = rmq_pkg::EXT_W'(mat.rot_11);
    e22    = rmq_pkg::EXT_W'(mat.rot_22);
    one    = rmq_pkg::EXT_W'(1) <<< rmq_pkg::FRAC_BITS;
    trace  = e00 + e11 + e22;
    d21_12 = rmq_pkg::NUM_W'(mat.rot_21) - rmq_pkg::NUM_W'(mat.rot_12);
    d02_20 = rmq_pkg::NUM_W'(mat.rot_02) - rmq_pkg::NUM_W'(mat.rot_20);
    d10_01 = rmq_pkg::NUM_W'(mat.rot_10) - rmq_pkg::NUM_W'(mat.rot_01);
    s01_10 = rmq_pkg::NUM_W'(mat.rot_01) + rmq_pkg::NUM_W'(mat.rot_10);
    s02_20 = rmq_pkg::NUM_W'(mat.rot_02) + rmq_pkg::NUM_W'(mat.rot_20);
    s12_21 = rmq_pkg::NUM_W'(mat.rot_12) + rmq_pkg::NUM_W'(mat.rot_21);
    if (trace > 0) begin
      nxt.sel = rmq_pkg::SEL_W;
      t       = one + trace;
      nxt.n0  = d21_12;
      nxt.n1  = d02_20;
      nxt.n2  = d10_01;
    end else if (mat.rot_00 > mat.rot_11 && mat.rot_00 > mat.rot_22) begin
      nxt.sel = rmq_pkg::SEL_X;
      t       = one + e00 - e11 - e22;
      nxt.n0  = d21_12;
      nxt.n1  = s01_10;
      nxt.n2  = s02_20;
    end else if (mat.rot_11 > mat.rot_22) begin
      nxt.sel = rmq_pkg::SEL_Y;
      t       = one + e11 - e00 - e22;
      nxt.n0  = d02_20;
      nxt.n1  = s01_10;
      nxt.n2  = s12_21;
    end else begin
      nxt.sel = rmq_pkg::SEL_Z;
      t       = one + e22 - e00 - e11;
      nxt.n0  = d10_01;
      nxt.n1  = s02_20;
      nxt.n2  = s12_21;
    end
    t_c      = (t < 1) ? rmq_pkg::T_W'(1) : t[rmq_pkg::T_W-1:0];
    nxt.rem  = rmq_pkg::V_W'(t_c) << rmq_pkg::FRAC_BITS;
    nxt.root = '0;
  end

  assign mat.ready = !vld || out_ready;
  assign out_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (mat.ready) begin
      vld <= mat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mat.ready) begin
      out_data <= nxt;
    end
  end

endmodule

// ===== sv/rmq_sqrt.sv =====
// Square-root pipeline: one root bit per register stage.
// Depends on rmq_pkg.
module rmq_sqrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rmq_pkg::sq_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rmq_pkg::sq_t  out_data
);

  localparam int N = rmq_pkg::SQ_STAGES;

  rmq_pkg::sq_t pipe_d [N+1];
  logic         pipe_v [N+1];
  logic         rdy    [N+1];

  assign pipe_d[0]  = in_data;
  assign pipe_v[0]  = in_valid;
  assign in_ready   = rdy[0];
  assign out_valid  = pipe_v[N];
  assign out_data   = pipe_d[N];

  for (genvar s = 1; s <= N; s++) begin : g_stage
    localparam int B = rmq_pkg::ROOT_W - s;
    logic [rmq_pkg::WIDE_W-1:0] inc;
    rmq_pkg::sq_t               nxt;

    assign rdy[s-1] = !pipe_v[s] || rdy[s];

    always_comb begin
      nxt = pipe_d[s-1];
      inc = (rmq_pkg::WIDE_W'(pipe_d[s-1].root) << (B + 1))
          + (rmq_pkg::WIDE_W'(1) << (2 * B));
      if (rmq_pkg::WIDE_W'(pipe_d[s-1].rem) >= inc) begin
        nxt.rem     = pipe_d[s-1].rem - inc[rmq_pkg::V_W-1:0];
        nxt.root[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe_v[s] <= 1'b0;
      end else if (rdy[s-1]) begin
        pipe_v[s] <= pipe_v[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s-1]) begin
        pipe_d[s] <= nxt;
      end
    end
  end

  assign rdy[N] = out_ready;

endmodule

// ===== sv/rmq_div.sv =====
// Divider pipeline: three lanes of rounded n * 2^F / (2r); copy, overflow check, then one quotient bit per stage.
// Depends on rmq_pkg.
module rmq_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rmq_pkg::sq_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rmq_pkg::dv_t  out_data
);

  localparam int N = rmq_pkg::DV_STAGES;

  rmq_pkg::dv_t pipe_d [N+1];
  logic         pipe_v [N+1];
  logic         rdy    [N+1];
  rmq_pkg::dv_t head;

  always_comb begin
    head.sel = in_data.sel;
    head.big = in_data.root[rmq_pkg::ROOT_W-1:1];
    head.den = {in_data.root, 1'b0};
    head.l0  = rmq_pkg::lane_init(in_data.n0, in_data.root);
    head.l1  = rmq_pkg::lane_init(in_data.n1, in_data.root);
    head.l2  = rmq_pkg::lane_init(in_data.n2, in_data.root);
  end

  assign pipe_d[0] = head;
  assign pipe_v[0] = in_valid;
  assign in_ready  = rdy[0];
  assign out_valid = pipe_v[N];
  assign out_data  = pipe_d[N];
  assign rdy[N]    = out_ready;

  for (genvar s = 1; s <= N; s++) begin : g_stage
    rmq_pkg::dv_t nxt;

    assign rdy[s-1] = !pipe_v[s] || rdy[s];

    if (s == 1) begin : g_copy
      assign nxt = pipe_d[0];
    end else if (s == 2) begin : g_ovf
      logic [rmq_pkg::WIDE_W-1:0] lim;
      always_comb begin
        nxt    = pipe_d[s-1];
        lim    = rmq_pkg::WIDE_W'(pipe_d[s-1].den) << rmq_pkg::Q_W;
        nxt.l0.ovf = rmq_pkg::WIDE_W'(pipe_d[s-1].l0.rem) >= lim;
        nxt.l1.ovf = rmq_pkg::WIDE_W'(pipe_d[s-1].l1.rem) >= lim;
        nxt.l2.ovf = rmq_pkg::WIDE_W'(pipe_d[s-1].l2.rem) >= lim;
      end
    end else begin : g_bit
      localparam int B = rmq_pkg::Q_W - 1 - (s - 3);
      logic [rmq_pkg::WIDE_W-1:0] sub;
      always_comb begin
        nxt = pipe_d[s-1];
        sub = rmq_pkg::WIDE_W'(pipe_d[s-1].den) << B;
        if (rmq_pkg::WIDE_W'(pipe_d[s-1].l0.rem) >= sub) begin
          nxt.l0.rem  = pipe_d[s-1].l0.rem - sub[rmq_pkg::V_W-1:0];
          nxt.l0.q[B] = 1'b1;
        end
        if (rmq_pkg::WIDE_W'(pipe_d[s-1].l1.rem) >= sub) begin
          nxt.l1.rem  = pipe_d[s-1].l1.rem - sub[rmq_pkg::V_W-1:0];
          nxt.l1.q[B] = 1'b1;
        end
        if (rmq_pkg::WIDE_W'(pipe_d[s-1].l2.rem) >= sub) begin
          nxt.l2.rem  = pipe_d[s-1].l2.rem - sub[rmq_pkg::V_W-1:0];
          nxt.l2.q[B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe_v[s] <= 1'b0;
      end else if (rdy[s-1]) begin
        pipe_v[s] <= pipe_v[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s-1]) begin
        pipe_d[s] <= nxt;
      end
    end
  end

endmodule

// ===== sv/rotation_matrix_to_quaternion.sv =====
// Converts one rotation matrix per cycle, while not stalled, to a unit quaternion
// (Shepperd method), all values signed Q2.30. Stages: one front stage, 32 square-root
// stages (one root bit each), 35 divider stages (round offset, overflow check, 33
// quotient bits for three lanes in parallel) and the saturating output register.
// Each stage holds on its own, so bubbles close up under a stall.
// Depends on rmq_pkg, rmq_mat_if, rmq_quat_if, rmq_front, rmq_sqrt, rmq_div.
module rotation_matrix_to_quaternion (
  input  logic       clk,
  input  logic       rst,
  rmq_mat_if.sink    mat,
  rmq_quat_if.source quat
);

  localparam logic [rmq_pkg::Q_W-1:0] NEG_LIM = rmq_pkg::Q_W'(1) << (rmq_pkg::DATA_WIDTH - 1);
  localparam logic [rmq_pkg::Q_W-1:0] POS_LIM = NEG_LIM - rmq_pkg::Q_W'(1);

  logic           f_valid, f_ready, s_valid, s_ready, d_valid, d_ready, ov;
  rmq_pkg::sq_t   f_data, s_data;
  rmq_pkg::dv_t   d_data;
  rmq_pkg::word_t big, c0, c1, c2;
  rmq_pkg::word_t w_next, x_next, y_next, z_next;

  function automatic rmq_pkg::word_t sat_lane(input rmq_pkg::lane_t l);
    rmq_pkg::word_t r;
    if (l.neg) begin
      if (l.ovf || l.q > NEG_LIM) begin
        r = {1'b1, {(rmq_pkg::DATA_WIDTH-1){1'b0}}};
      end else begin
        r = rmq_pkg::DATA_WIDTH'(rmq_pkg::Q_W'(0) - l.q);
      end
    end else begin
      if (l.ovf || l.q > POS_LIM) begin
        r = {1'b0, {(rmq_pkg::DATA_WIDTH-1){1'b1}}};
      end else begin
        r = l.q[rmq_pkg::DATA_WIDTH-1:0];
      end
    end
    return r;
  endfunction

  rmq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .mat       (mat),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_data  (f_data)
  );

  rmq_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_data  (s_data)
  );

  rmq_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_data   (s_data),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_data  (d_data)
  );

  always_comb begin
    big = rmq_pkg::DATA_WIDTH'(d_data.big);
    c0  = sat_lane(d_data.l0);
    c1  = sat_lane(d_data.l1);
    c2  = sat_lane(d_data.l2);
    case (d_data.sel)
      rmq_pkg::SEL_W: begin
        w_next = big; x_next = c0;  y_next = c1;  z_next = c2;
      end
      rmq_pkg::SEL_X: begin
        w_next = c0;  x_next = big; y_next = c1;  z_next = c2;
      end
      rmq_pkg::SEL_Y: begin
        w_next = c0;  x_next = c1;  y_next = big; z_next = c2;
      end
      default: begin
        w_next = c0;  x_next = c1;  y_next = c2;  z_next = big;
      end
    endcase
  end

  assign d_ready    = !ov || quat.ready;
  assign quat.valid = ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (d_ready) begin
      ov <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready) begin
      quat.quat_w <= w_next;
      quat.quat_x <= x_next;
      quat.quat_y <= y_next;
      quat.quat_z <= z_next;
    end
  end

endmodule

// ===== verif/rotation_matrix_to_quaternion_tb.sv =====
// Testbench for rotation_matrix_to_quaternion: drives matrices through rmq_mat_if, checks
// quaternions on rmq_quat_if against an in-bench fixed-point Shepperd predictor.
// Depends on rmq_pkg, rmq_mat_if, rmq_quat_if and the block's RTL.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_tb;

  localparam int LATENCY   = 69;
  localparam int WATCH_MAX = 4000;
  localparam int N_RANDOM  = 1250;
  localparam int CALM_FROM = 1100;

  typedef struct {
    rmq_pkg::word_t w;
    rmq_pkg::word_t x;
    rmq_pkg::word_t y;
    rmq_pkg::word_t z;
  } quat_t;

  typedef struct {
    rmq_pkg::word_t m[9];
    logic           known;
    quat_t          q;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  rmq_mat_if  mat ();
  rmq_quat_if quat ();

  rotation_matrix_to_quaternion dut (.clk(clk), .rst(rst), .mat(mat), .quat(quat));

  quat_t expected_quats[$];
  int    errors = 0;
  int    acc_cnt = 0;
  int    idle_cnt = 0;
  bit    hold_off = 1'b0;
  bit    calm = 1'b0;
  row_t  rows[$];

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint scale_by_root(input longint n, input longint unsigned r);
    longint unsigned mag, q;
    mag = (n < 0) ? -n : n;
    q   = ((mag << rmq_pkg::FRAC_BITS) + r) / (2 * r);
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic rmq_pkg::word_t clamp_word(input longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (rmq_pkg::DATA_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return rmq_pkg::word_t'(v);
  endfunction

  function automatic quat_t shepperd_quat(input rmq_pkg::word_t m[9]);
    longint          a[9];
    longint          one, tr, t, big, w, x, y, z;
    longint unsigned r;
    rmq_pkg::sel_t   sel;
    quat_t           q;
    foreach (a[i]) a[i] = longint'(m[i]);
    one = longint'(1) <<< rmq_pkg::FRAC_BITS;
    tr  = a[0] + a[4] + a[8];
    if (tr > 0) begin
      sel = rmq_pkg::SEL_W; t = one + tr;
    end else if (a[0] > a[4] && a[0] > a[8]) begin
      sel = rmq_pkg::SEL_X; t = one + a[0] - a[4] - a[8];
    end else if (a[4] > a[8]) begin
      sel = rmq_pkg::SEL_Y; t = one + a[4] - a[0] - a[8];
    end else begin
      sel = rmq_pkg::SEL_Z; t = one + a[8] - a[0] - a[4];
    end
    if (t < 1) t = 1;
    r   = int_sqrt(unsigned'(t) << rmq_pkg::FRAC_BITS);
    big = longint'(r >> 1);
    case (sel)
      rmq_pkg::SEL_W: begin
        w = big;
        x = scale_by_root(a[7] - a[5], r);
        y = scale_by_root(a[2] - a[6], r);
        z = scale_by_root(a[3] - a[1], r);
      end
      rmq_pkg::SEL_X: begin
        w = scale_by_root(a[7] - a[5], r);
        x = big;
        y = scale_by_root(a[1] + a[3], r);
        z = scale_by_root(a[2] + a[6], r);
      end
      rmq_pkg::SEL_Y: begin
        w = scale_by_root(a[2] - a[6], r);
        x = scale_by_root(a[1] + a[3], r);
        y = big;
        z = scale_by_root(a[5] + a[7], r);
      end
      default: begin
        w = scale_by_root(a[3] - a[1], r);
        x = scale_by_root(a[2] + a[6], r);
        y = scale_by_root(a[5] + a[7], r);
        z = big;
      end
    endcase
    q.w = clamp_word(w);
    q.x = clamp_word(x);
    q.y = clamp_word(y);
    q.z = clamp_word(z);
    return q;
  endfunction

  function automatic rmq_pkg::word_t rand_elem(input int mode);
    case (mode)
      0: return rmq_pkg::word_t'($urandom);
      1: return rmq_pkg::word_t'(int'($urandom_range(2147483647)) - 1073741824);
      default: return rmq_pkg::word_t'(int'($urandom_range(8192)) - 4096);
    endcase
  endfunction

  // Build a near-rotation matrix from a random quaternion; the caller may put noise on one entry.
  function automatic void rand_rotation(output rmq_pkg::word_t m[9]);
    real qw, qx, qy, qz, nrm, f[9];
    qw = $urandom_range(2000) / 1000.0 - 1.0;
    qx = $urandom_range(2000) / 1000.0 - 1.0;
    qy = $urandom_range(2000) / 1000.0 - 1.0;
    qz = $urandom_range(2000) / 1000.0 - 1.0;
    nrm = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
    if (nrm < 0.01) begin
      qw = 1.0; nrm = 1.0;
    end
    qw /= nrm; qx /= nrm; qy /= nrm; qz /= nrm;
    f[0] = 1 - 2 * (qy * qy + qz * qz); f[1] = 2 * (qx * qy - qz * qw);
    f[2] = 2 * (qx * qz + qy * qw);     f[3] = 2 * (qx * qy + qz * qw);
    f[4] = 1 - 2 * (qx * qx + qz * qz); f[5] = 2 * (qy * qz - qx * qw);
    f[6] = 2 * (qx * qz - qy * qw);     f[7] = 2 * (qy * qz + qx * qw);
    f[8] = 1 - 2 * (qx * qx + qy * qy);
    foreach (m[i]) m[i] = rmq_pkg::word_t'(longint'(f[i] * 1073741824.0));
  endfunction

  task automatic add_row(input rmq_pkg::word_t m[9], input logic known, input quat_t q);
    row_t rw;
    rw.m = m; rw.known = known; rw.q = q;
    rows = {rows, rw};
  endtask

  task automatic build_directed();
    rmq_pkg::word_t m[9];
    quat_t q, nq;
    localparam rmq_pkg::word_t P1 = 32'sh4000_0000;
    localparam rmq_pkg::word_t N1 = -32'sh4000_0000;
    localparam rmq_pkg::word_t MX = 32'sh7fff_ffff;
    localparam rmq_pkg::word_t MN = 32'sh8000_0000;
    nq = '{default: '0};
    // identity: trace branch, w = 1.0
    m = '{P1, 0, 0, 0, P1, 0, 0, 0, P1};
    q = '{w: P1, x: 0, y: 0, z: 0};
    add_row(m, 1'b1, q);
    // 180 deg about x, y, z
    m = '{P1, 0, 0, 0, N1, 0, 0, 0, N1};
    q = '{w: 0, x: P1, y: 0, z: 0};
    add_row(m, 1'b1, q);
    m = '{N1, 0, 0, 0, P1, 0, 0, 0, N1};
    q = '{w: 0, x: 0, y: P1, z: 0};
    add_row(m, 1'b1, q);
    m = '{N1, 0, 0, 0, N1, 0, 0, 0, P1};
    q = '{w: 0, x: 0, y: 0, z: P1};
    add_row(m, 1'b1, q);
    // all zero: diagonal tie falls to z branch
    m = '{default: '0};
    add_row(m, 1'b0, nq);
    // tie m00 == m11 > m22
    m = '{N1 / 2, 5, 7, 9, N1 / 2, 11, 13, 17, N1};
    add_row(m, 1'b0, nq);
    // clamped sqrt argument, saturating lanes
    m = '{MN, MX, MN, MX, MN, MX, MN, MX, MN};
    add_row(m, 1'b0, nq);
    m = '{N1, MX, MN, MN, N1, MX, MX, MN, N1};
    add_row(m, 1'b0, nq);
    m = '{MX, MX, MX, MX, MX, MX, MX, MX, MX};
    add_row(m, 1'b0, nq);
    m = '{MN, MN, MN, MN, MN, MN, MN, MN, MN};
    add_row(m, 1'b0, nq);
    m = '{MX, MN, MX, MN, MN, MN, MX, MX, MN};
    add_row(m, 1'b0, nq);
    m = '{-1, -1, -1, -1, -1, -1, -1, -1, 1};
    add_row(m, 1'b0, nq);
    m = '{1, 0, 0, 0, 0, 0, 0, 0, 0};
    add_row(m, 1'b0, nq);
    m = '{0, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555, 0, 32'shaaaa_aaaa,
          32'sh5555_5555, 32'shaaaa_aaaa, 0};
    add_row(m, 1'b0, nq);
    m = '{0, 32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa, 0, 32'sh5555_5555,
          32'shaaaa_aaaa, 32'sh5555_5555, 0};
    add_row(m, 1'b0, nq);
  endtask

  task automatic send_matrix(input rmq_pkg::word_t m[9]);
    mat.valid  <= 1'b1;
    mat.rot_00 <= m[0]; mat.rot_01 <= m[1]; mat.rot_02 <= m[2];
    mat.rot_10 <= m[3]; mat.rot_11 <= m[4]; mat.rot_12 <= m[5];
    mat.rot_20 <= m[6]; mat.rot_21 <= m[7]; mat.rot_22 <= m[8];
    @(posedge clk);
    while (!mat.ready) @(posedge clk);
  endtask

  task automatic sender_gap();
    int n;
    if (!calm && $urandom_range(5) == 0) begin
      n = $urandom_range(4, 1);
      mat.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Record expectations at the accepting edge; directed rows with a typed answer use it.
  always @(posedge clk) begin
    rmq_pkg::word_t m[9];
    quat_t          e;
    if (!rst && mat.valid && mat.ready) begin
      m = '{mat.rot_00, mat.rot_01, mat.rot_02, mat.rot_10, mat.rot_11, mat.rot_12,
            mat.rot_20, mat.rot_21, mat.rot_22};
      e = shepperd_quat(m);
      if (acc_cnt < rows.size() && rows[acc_cnt].known) e = rows[acc_cnt].q;
      expected_quats = {expected_quats, e};
      acc_cnt++;
    end
  end

  always @(posedge clk) begin
    quat_t e;
    if (!rst && quat.valid && quat.ready) begin
      if (expected_quats.size() == 0) begin
        $error("unexpected quaternion word w=%h", quat.quat_w);
        errors++;
      end else begin
        e = expected_quats.pop_front();
        if (quat.quat_w !== e.w) begin
          $error("quat_w expected %h actual %h", e.w, quat.quat_w); errors++;
        end
        if (quat.quat_x !== e.x) begin
          $error("quat_x expected %h actual %h", e.x, quat.quat_x); errors++;
        end
        if (quat.quat_y !== e.y) begin
          $error("quat_y expected %h actual %h", e.y, quat.quat_y); errors++;
        end
        if (quat.quat_z !== e.z) begin
          $error("quat_z expected %h actual %h", e.z, quat.quat_z); errors++;
        end
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off while the sender keeps going.
  initial begin
    int n;
    quat.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        quat.ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
        quat.ready <= 1'b1;
      end else if (!calm && $urandom_range(5) == 0) begin
        n = $urandom_range(4, 1);
        quat.ready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end else begin
        quat.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (mat.valid && mat.ready) || (quat.valid && quat.ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCH_MAX) begin
        $display("rotation_matrix_to_quaternion verification failed");
        $finish;
      end
    end
  end

  initial begin
    rmq_pkg::word_t m[9];
    int             mode, drain;
    mat.valid  <= 1'b0;
    mat.rot_00 <= '0; mat.rot_01 <= '0; mat.rot_02 <= '0;
    mat.rot_10 <= '0; mat.rot_11 <= '0; mat.rot_12 <= '0;
    mat.rot_20 <= '0; mat.rot_21 <= '0; mat.rot_22 <= '0;
    build_directed();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      send_matrix(rows[i].m);
      sender_gap();
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) hold_off = 1'b1;
      if (i == CALM_FROM) calm = 1'b1;
      mode = $urandom_range(9);
      if (mode < 7) begin
        rand_rotation(m);
        if (mode == 6) m[$urandom_range(8)] = rand_elem($urandom_range(2));
      end else begin
        foreach (m[k]) m[k] = rand_elem(mode - 7);
      end
      send_matrix(m);
      sender_gap();
    end
    mat.valid <= 1'b0;
    drain = 0;
    while (expected_quats.size() != 0 && drain < 20 * LATENCY) begin
      @(posedge clk);
      drain++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("rotation_matrix_to_quaternion verification clean");
    end else begin
      $display("rotation_matrix_to_quaternion verification failed");
    end
    $finish;
  end
endmodule
